### hw/rtl/alen_pkg.sv
// Package: command and status codes for the array list engine.
package alen_pkg;

   typedef enum logic [3:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_INSERT     = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_POP_BACK   = 4'd4,
      CMD_DELETE     = 4'd5,
      CMD_SORT       = 4'd6,
      CMD_LSEARCH    = 4'd7,
      CMD_BSEARCH    = 4'd8,
      CMD_READ       = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage

### hw/rtl/alen_mem.sv
// Element store: one write port, one read port, registered read data.
module alen_mem #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32,
   parameter int AW        = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic signed [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic signed [WORD_BITS-1:0] rd_data
);

   logic signed [WORD_BITS-1:0] mem [DEPTH];
   logic signed [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/array_list_engine_top.sv
// Top level: array list engine with command sequencer over the element store.
// Rejects, no-ops, pop back and pops/deletes that move nothing answer from idle; push and
// insert shift elements up, a read and a write per moved element, then write the new
// value; pop front and delete shift down likewise; read, searches and sort run as reads
// and compares. One item at a time; result strobe lasts one cycle, no stall.
// Synchronous reset empties the list; store contents stay undefined until written.
module array_list_engine_top #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  alen_pkg::cmd_type      req_command,
   input  logic signed [31:0]     req_value,
   input  logic [6:0]             req_position,
   output logic                   rsp_strobe,
   output alen_pkg::status_type   rsp_status,
   output logic [6:0]             rsp_found_position,
   output logic signed [31:0]     rsp_read_value,
   output logic [6:0]             rsp_count
);
   import alen_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 7) ? CW : 7;

   typedef enum logic [3:0] {
      S_IDLE, S_SH_RD, S_SH_WR, S_FIN_WR, S_DN_RD, S_DN_WR, S_RD_RD, S_RD_WAIT,
      S_LS_RD, S_LS_CMP, S_BS_RD, S_BS_CMP, S_SO_KR, S_SO_KL, S_SO_CR, S_SO_CMP
   } state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff, i_ff, j_ff, p0_ff, mid_ff;
   logic signed [CW:0] lo_ff, hi_ff;
   logic signed [WORD_BITS-1:0] key_ff, val_ff;
   status_type status_ff;
   logic [CW-1:0] found_ff;
   logic signed [31:0] readv_ff;
   logic strobe_ff;
   logic put_ff;

   logic wr_en;
   logic [AW-1:0] wa, ra;
   logic signed [WORD_BITS-1:0] wd, rd_data;
   logic [PW-1:0] posx, nx;
   logic pos_ok;
   logic [CW-1:0] pos_m1;
   logic [CW+1:0] bs_sum;
   logic [CW-1:0] bs_mid;
   logic signed [CW:0] nlo, nhi;
   logic signed [WORD_BITS-1:0] in_word;

   alen_mem #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (ra),
      .rd_data (rd_data)
   );

   assign posx    = PW'(req_position);
   assign nx      = PW'(cnt_ff);
   assign pos_ok  = (posx >= PW'(1)) && (posx <= nx);
   assign pos_m1  = CW'(posx - PW'(1));
   assign in_word = WORD_BITS'(req_value);
   assign bs_sum  = (CW+2)'(lo_ff) + (CW+2)'(hi_ff);
   assign bs_mid  = CW'(bs_sum >> 1);
   assign nlo     = $signed({1'b0, mid_ff}) + (CW+1)'(1);
   assign nhi     = $signed({1'b0, mid_ff}) - (CW+1)'(1);

   always_comb begin
      wr_en = 1'b0;
      wa    = AW'(i_ff);
      wd    = rd_data;
      ra    = AW'(i_ff);
      unique case (state_ff)
         S_SH_RD:  ra = AW'(i_ff - CW'(1));
         S_SH_WR:  wr_en = 1'b1;
         S_FIN_WR: begin
            wr_en = 1'b1;
            wa    = AW'(p0_ff);
            wd    = val_ff;
         end
         S_DN_RD:  ra = AW'(i_ff + CW'(1));
         S_DN_WR:  wr_en = 1'b1;
         S_RD_RD:  ra = AW'(p0_ff);
         S_BS_RD:  ra = AW'(bs_mid);
         S_SO_CR:  ra = AW'(j_ff - CW'(1));
         S_SO_CMP: begin
            wa = AW'(j_ff);
            if (put_ff) begin
               wr_en = 1'b1;
               wd    = key_ff;
            end else if (rd_data > key_ff) begin
               wr_en = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         put_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  status_ff <= ST_OK;
                  found_ff  <= '0;
                  readv_ff  <= '0;
                  val_ff    <= in_word;
                  put_ff    <= 1'b0;
                  unique case (req_command)
                     CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                        if (cnt_ff == CW'(DEPTH)) begin
                           status_ff <= ST_FULL;
                           strobe_ff <= 1'b1;
                        end else if (req_command == CMD_INSERT && !pos_ok) begin
                           status_ff <= ST_BADPOS;
                           strobe_ff <= 1'b1;
                        end else begin
                           i_ff <= cnt_ff;
                           if (req_command == CMD_PUSH_FRONT) begin
                              p0_ff    <= '0;
                              state_ff <= (cnt_ff == '0) ? S_FIN_WR : S_SH_RD;
                           end else if (req_command == CMD_PUSH_BACK) begin
                              p0_ff    <= cnt_ff;
                              state_ff <= S_FIN_WR;
                           end else begin
                              p0_ff    <= pos_m1;
                              state_ff <= S_SH_RD;
                           end
                        end
                     end
                     CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE, CMD_READ: begin
                        if (cnt_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           strobe_ff <= 1'b1;
                        end else if ((req_command == CMD_DELETE ||
                                      req_command == CMD_READ) && !pos_ok) begin
                           status_ff <= ST_BADPOS;
                           strobe_ff <= 1'b1;
                        end else if (req_command == CMD_READ) begin
                           p0_ff    <= pos_m1;
                           state_ff <= S_RD_RD;
                        end else if (req_command == CMD_POP_BACK) begin
                           cnt_ff    <= cnt_ff - CW'(1);
                           strobe_ff <= 1'b1;
                        end else begin
                           i_ff <= (req_command == CMD_POP_FRONT) ? '0 : pos_m1;
                           if (((req_command == CMD_POP_FRONT) ? CW'(1) :
                                CW'(posx)) < cnt_ff) begin
                              state_ff <= S_DN_RD;
                           end else begin
                              cnt_ff    <= cnt_ff - CW'(1);
                              strobe_ff <= 1'b1;
                           end
                        end
                     end
                     CMD_SORT: begin
                        i_ff <= CW'(1);
                        if (cnt_ff > CW'(1)) begin
                           state_ff <= S_SO_KR;
                        end else begin
                           strobe_ff <= 1'b1;
                        end
                     end
                     CMD_LSEARCH: begin
                        status_ff <= ST_NOTFOUND;
                        i_ff      <= '0;
                        if (cnt_ff == '0) begin
                           strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= S_LS_RD;
                        end
                     end
                     CMD_BSEARCH: begin
                        status_ff <= ST_NOTFOUND;
                        lo_ff     <= '0;
                        hi_ff     <= $signed({1'b0, cnt_ff}) - (CW+1)'(1);
                        if (cnt_ff == '0) begin
                           strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= S_BS_RD;
                        end
                     end
                     default: strobe_ff <= 1'b1;
                  endcase
               end
            end
            S_SH_RD: state_ff <= S_SH_WR;
            S_SH_WR: begin
               i_ff     <= i_ff - CW'(1);
               state_ff <= (i_ff - CW'(1) == p0_ff) ? S_FIN_WR : S_SH_RD;
            end
            S_FIN_WR: begin
               cnt_ff    <= cnt_ff + CW'(1);
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            S_DN_RD: state_ff <= S_DN_WR;
            S_DN_WR: begin
               i_ff <= i_ff + CW'(1);
               if (i_ff + CW'(2) < cnt_ff) begin
                  state_ff <= S_DN_RD;
               end else begin
                  cnt_ff    <= cnt_ff - CW'(1);
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_RD_RD: state_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               readv_ff  <= 32'(rd_data);
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            S_LS_RD: state_ff <= S_LS_CMP;
            S_LS_CMP: begin
               i_ff <= i_ff + CW'(1);
               if (rd_data == val_ff) begin
                  status_ff <= ST_OK;
                  found_ff  <= i_ff + CW'(1);
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else if (i_ff + CW'(1) < cnt_ff) begin
                  state_ff <= S_LS_RD;
               end else begin
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_BS_RD: begin
               mid_ff   <= bs_mid;
               state_ff <= S_BS_CMP;
            end
            S_BS_CMP: begin
               if (rd_data == val_ff) begin
                  status_ff <= ST_OK;
                  found_ff  <= mid_ff + CW'(1);
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else if (rd_data > val_ff) begin
                  hi_ff <= nhi;
                  if (lo_ff <= nhi) begin
                     state_ff <= S_BS_RD;
                  end else begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end else begin
                  lo_ff <= nlo;
                  if (nlo <= hi_ff) begin
                     state_ff <= S_BS_RD;
                  end else begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            S_SO_KR: state_ff <= S_SO_KL;
            S_SO_KL: begin
               key_ff   <= rd_data;
               j_ff     <= i_ff;
               state_ff <= S_SO_CR;
            end
            S_SO_CR: state_ff <= S_SO_CMP;
            S_SO_CMP: begin
               if (put_ff) begin
                  put_ff <= 1'b0;
                  i_ff   <= i_ff + CW'(1);
                  if (i_ff + CW'(1) < cnt_ff) begin
                     state_ff <= S_SO_KR;
                  end else begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end else if (rd_data > key_ff) begin
                  j_ff <= j_ff - CW'(1);
                  if (j_ff == CW'(1)) begin
                     put_ff <= 1'b1;
                  end else begin
                     state_ff <= S_SO_CR;
                  end
               end else begin
                  put_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = 7'(found_ff);
   assign rsp_read_value     = readv_ff;
   assign rsp_count          = 7'(cnt_ff);

endmodule

### dv/array_list_engine_top_tb.sv
// Testbench: directed and random command traffic for the array list engine, self-checked.
`timescale 1ns / 1ps

module array_list_engine_top_tb;
   import alen_pkg::*;

   localparam int DEPTH       = 64;
   localparam int CLK_HALF    = 6;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int RAND_ITEMS  = 800;
   localparam int N_DIRECTED  = 25;
   localparam int EXP_DEPTH   = 16;

   typedef struct {
      status_type        st;
      logic [6:0]        fpos;
      logic signed [31:0] rval;
      logic [6:0]        cnt;
   } result_t;

   typedef struct {
      cmd_type           cmd;
      logic signed [31:0] val;
      logic [6:0]        pos;
      bit                typed;
      result_t           res;
   } row_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   cmd_type            req_command;
   logic signed [31:0] req_value;
   logic [6:0]         req_position;
   logic               rsp_strobe;
   status_type         rsp_status;
   logic [6:0]         rsp_found_position;
   logic signed [31:0] rsp_read_value;
   logic [6:0]         rsp_count;

   logic signed [31:0] list_model [DEPTH];
   int                 list_n = 0;
   result_t            exp_fifo [EXP_DEPTH];
   int                 exp_wr = 0;
   int                 exp_rd = 0;
   int                 errors = 0;
   int                 cycles = 0;
   int                 accepted = 0;
   int                 checked = 0;
   int                 full_hits = 0;
   int                 empty_hits = 0;

   row_t dir_rows [N_DIRECTED] = '{
      '{CMD_READ,       0,               1,   1, '{ST_EMPTY,    0, 0,               0}},
      '{CMD_POP_FRONT,  0,               0,   1, '{ST_EMPTY,    0, 0,               0}},
      '{CMD_DELETE,     0,               1,   1, '{ST_EMPTY,    0, 0,               0}},
      '{CMD_INSERT,     5,               1,   1, '{ST_BADPOS,   0, 0,               0}},
      '{CMD_LSEARCH,    0,               0,   1, '{ST_NOTFOUND, 0, 0,               0}},
      '{CMD_BSEARCH,    0,               0,   1, '{ST_NOTFOUND, 0, 0,               0}},
      '{CMD_SORT,       0,               0,   1, '{ST_OK,       0, 0,               0}},
      '{cmd_type'(4'd15), -1,            127, 1, '{ST_OK,       0, 0,               0}},
      '{CMD_PUSH_BACK,  32'sh7fffffff,   0,   1, '{ST_OK,       0, 0,               1}},
      '{CMD_PUSH_FRONT, 32'sh80000000,   0,   1, '{ST_OK,       0, 0,               2}},
      '{CMD_READ,       0,               1,   1, '{ST_OK,       0, 32'sh80000000,   2}},
      '{CMD_READ,       0,               2,   1, '{ST_OK,       0, 32'sh7fffffff,   2}},
      '{CMD_READ,       0,               0,   1, '{ST_BADPOS,   0, 0,               2}},
      '{CMD_READ,       0,               127, 1, '{ST_BADPOS,   0, 0,               2}},
      '{CMD_INSERT,     7,               3,   1, '{ST_BADPOS,   0, 0,               2}},
      '{CMD_INSERT,     7,               2,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_DELETE,     0,               64,  1, '{ST_BADPOS,   0, 0,               3}},
      '{CMD_LSEARCH,    7,               0,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_BSEARCH,    7,               0,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_SORT,       0,               0,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_BSEARCH,    32'sh80000000,   0,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_POP_BACK,   0,               0,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_DELETE,     0,               1,   0, '{ST_OK,       0, 0,               0}},
      '{CMD_POP_FRONT,  0,               0,   1, '{ST_OK,       0, 0,               0}},
      '{CMD_POP_BACK,   0,               0,   1, '{ST_EMPTY,    0, 0,               0}}
   };

   array_list_engine_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_value(req_value), .req_position(req_position),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position), .rsp_read_value(rsp_read_value),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic result_t list_apply(cmd_type cmd, logic signed [31:0] val,
                                          logic [6:0] pos);
      result_t r;
      int n, p, lo, hi, mid, j;
      logic signed [31:0] key;
      r = '{ST_OK, 0, 0, 0};
      n = list_n;
      p = int'(pos);
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (cmd == CMD_PUSH_FRONT) p = 1;
            else if (cmd == CMD_PUSH_BACK) p = n + 1;
            if (n >= DEPTH) r.st = ST_FULL;
            else if (cmd == CMD_INSERT && (p < 1 || p > n)) r.st = ST_BADPOS;
            else begin
               for (int i = n; i > p - 1; i--) list_model[i] = list_model[i - 1];
               list_model[p - 1] = val;
               list_n = n + 1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE, CMD_READ: begin
            if (cmd == CMD_POP_FRONT) p = 1;
            else if (cmd == CMD_POP_BACK) p = n;
            if (n == 0) r.st = ST_EMPTY;
            else if (p < 1 || p > n) r.st = ST_BADPOS;
            else if (cmd == CMD_READ) r.rval = list_model[p - 1];
            else begin
               for (int i = p - 1; i + 1 < n; i++) list_model[i] = list_model[i + 1];
               list_n = n - 1;
            end
         end
         CMD_SORT: begin
            for (int i = 1; i < n; i++) begin
               key = list_model[i];
               j = i;
               while (j > 0 && list_model[j - 1] > key) begin
                  list_model[j] = list_model[j - 1];
                  j--;
               end
               list_model[j] = key;
            end
         end
         CMD_LSEARCH: begin
            r.st = ST_NOTFOUND;
            for (int i = 0; i < n; i++)
               if (r.st == ST_NOTFOUND && list_model[i] == val) begin
                  r.st = ST_OK;
                  r.fpos = 7'(i + 1);
               end
         end
         CMD_BSEARCH: begin
            r.st = ST_NOTFOUND;
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (list_model[mid] == val) begin
                  r.st = ST_OK;
                  r.fpos = 7'(mid + 1);
                  break;
               end
               if (list_model[mid] > val) hi = mid - 1;
               else lo = mid + 1;
            end
         end
         default: ;
      endcase
      r.cnt = 7'(list_n);
      return r;
   endfunction

   task automatic send_cmd(cmd_type cmd, logic signed [31:0] val, logic [6:0] pos,
                           bit typed, result_t typed_res);
      result_t r;
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_value = val;
      req_position = pos;
      do @(posedge clock); while (busy);
      r = list_apply(cmd, val, pos);
      if (r.st == ST_FULL) full_hits++;
      if (r.st == ST_EMPTY) empty_hits++;
      exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_res : r;
      exp_wr++;
      accepted++;
   endtask

   task automatic idle_gap(bit allow);
      if (allow && $urandom_range(99) < 17) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      int k;
      k = $urandom_range(9);
      if (k < 5) return $signed($urandom_range(16)) - 8;
      if (k < 7) return $urandom;
      if (k == 7) return 32'sh7fffffff;
      if (k == 8) return 32'sh80000000;
      if (list_n > 0) return list_model[$urandom_range(list_n - 1)];
      return -1;
   endfunction

   function automatic logic [6:0] pick_position();
      int n;
      n = list_n;
      if ($urandom_range(9) == 0) return 7'($urandom_range(127));
      return 7'($urandom_range(n + 1));
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results outstanding", $time, exp_wr - exp_rd);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_t e;
      if (!reset && rsp_strobe) begin
         if (exp_wr == exp_rd) begin
            $display("%0t unexpected result transfer: status %0d count %0d",
                     $time, rsp_status, rsp_count);
            errors++;
         end else begin
            e = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            checked++;
            if (rsp_status !== e.st) begin
               $display("%0t status exp %0d got %0d", $time, e.st, rsp_status);
               errors++;
            end
            if (rsp_found_position !== e.fpos) begin
               $display("%0t found_position exp %0d got %0d",
                        $time, e.fpos, rsp_found_position);
               errors++;
            end
            if (rsp_read_value !== e.rval) begin
               $display("%0t read_value exp %0d got %0d", $time, e.rval, rsp_read_value);
               errors++;
            end
            if (rsp_count !== e.cnt) begin
               $display("%0t count exp %0d got %0d", $time, e.cnt, rsp_count);
               errors++;
            end
         end
      end
   end

   initial begin
      cmd_type c;
      int k;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_PUSH_FRONT;
      req_value = '0;
      req_position = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         send_cmd(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].pos,
                  dir_rows[i].typed, dir_rows[i].res);
         idle_gap(1'b1);
      end

      // drain before the random part
      @(negedge clock);
      start = 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         k = $urandom_range(99);
         if (i >= 400 && i < 480) begin
            c = (k < 85) ? cmd_type'($urandom_range(2)) : CMD_READ;
         end else if (i >= 480 && i < 560) begin
            c = (k < 85) ? cmd_type'(3 + $urandom_range(2)) : CMD_LSEARCH;
         end else if (k < 35) c = cmd_type'($urandom_range(2));
         else if (k < 62) c = cmd_type'(3 + $urandom_range(2));
         else if (k < 67) c = CMD_SORT;
         else if (k < 77) c = CMD_LSEARCH;
         else if (k < 87) c = CMD_BSEARCH;
         else if (k < 97) c = CMD_READ;
         else c = cmd_type'(10 + $urandom_range(5));
         send_cmd(c, pick_value(), pick_position(), 1'b0, '{ST_OK, 0, 0, 0});
         idle_gap(!(i >= 200 && i < 350));
      end

      @(negedge clock);
      start = 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (2 * DEPTH * DEPTH) @(posedge clock);

      $display("Ran %0d commands, checked %0d results (%0d full, %0d empty rejections).",
               accepted, checked, full_hits, empty_hits);
      if (errors == 0 && exp_wr == exp_rd)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
